FILE: rtl/core/assert_macros.svh
// Assertion macros used by the engine and the top-level module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge of clk outside reset.
`define ASSERT_CLKD(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

// Check a property on every rising edge of clk, reset included.
`define ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("assertion failed");

`endif

FILE: rtl/core/tlbp_pkg.sv
// Types, constants and tables of the two-LED breathing pattern block.
package tlbp_pkg;

  localparam int MAX_DUTY   = 100;
  localparam int RAMP_STEPS = 10;
  localparam int PWM_PERIOD = 1200;

  localparam int DUTY_W = 7;
  localparam int CMP_W  = 11;
  localparam int TMR_W  = 11;

  localparam logic [7:0]        PAT_BLINK   = 8'hAA;
  localparam logic [7:0]        PAT_SOLID   = 8'hFF;
  localparam logic [TMR_W-1:0]  BLINK_MS    = TMR_W'(500);
  localparam logic [TMR_W-1:0]  RELOAD_MS   = TMR_W'(1500 / RAMP_STEPS);
  localparam logic [DUTY_W-1:0] DUTY_MAX    = DUTY_W'(MAX_DUTY);
  localparam logic [DUTY_W-1:0] STEP_RAMP   = DUTY_W'(MAX_DUTY / RAMP_STEPS);

  // Operation codes of an input beat.
  localparam logic OP_TICK = 1'b0;
  localparam logic OP_MODE = 1'b1;

  // Configuration register indexes.
  localparam logic [1:0] CFG_DISPLAY_EN = 2'd0;
  localparam logic [1:0] CFG_LOW_BAT    = 2'd1;
  localparam logic [1:0] CFG_WPS        = 2'd2;
  localparam logic [1:0] CFG_NIGHT      = 2'd3;

  typedef struct packed {
    logic       operation;
    logic [2:0] mode_index;
    logic       mode_on;
    logic       module_active;
    logic       sleep_leds_off;
    logic       test_blink;
  } in_item_t;

  typedef struct packed {
    logic [DUTY_W-1:0] red_drive;
    logic [DUTY_W-1:0] blue_drive;
    logic [CMP_W-1:0]  red_compare;
    logic [CMP_W-1:0]  blue_compare;
    logic [7:0]        active_modes;
  } out_item_t;

  typedef struct packed {
    logic       led_display_enabled;
    logic [2:0] low_battery_bit;
    logic [2:0] wps_bit;
    logic [2:0] night_lamp_bit;
  } cfg_t;

  // Engine results handed to the output stage.
  typedef struct packed {
    logic [DUTY_W-1:0] red_drive;
    logic [DUTY_W-1:0] blue_drive;
    logic [7:0]        active_modes;
  } res_t;

  typedef logic [CMP_W-1:0] cmp_lut_t [2**DUTY_W];

  function automatic cmp_lut_t build_cmp_lut();
    cmp_lut_t t;
    for (int i = 0; i < 2**DUTY_W; i++) begin
      t[i] = CMP_W'((PWM_PERIOD * i) / 100);
    end
    return t;
  endfunction

  localparam cmp_lut_t CMP_LUT = build_cmp_lut();

endpackage

FILE: rtl/core/tlbp_in_stage.sv
// Input register: holds one accepted beat until the engine takes it.
module tlbp_in_stage (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  tlbp_pkg::in_item_t in_data,
  input  logic               take,
  output logic               item_valid,
  output tlbp_pkg::in_item_t item
);
  import tlbp_pkg::*;

  logic     valid_r, valid_nxt;
  in_item_t item_r;

  assign in_ready   = !valid_r || take;
  assign valid_nxt  = in_ready ? in_valid : valid_r;
  assign item_valid = valid_r;
  assign item       = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item_r <= in_data;
    end
  end

endmodule

FILE: rtl/core/tlbp_engine.sv
// Mode, pattern, ramp and timer state with its per-beat update.
module tlbp_engine (
  input  logic               clk,
  input  logic               rst_n,
  input  tlbp_pkg::cfg_t     cfg,
  input  logic               take,
  input  tlbp_pkg::in_item_t item,
  output tlbp_pkg::res_t     res
);
  import tlbp_pkg::*;

  `include "assert_macros.svh"

  logic [7:0]        mode_bits_r, mode_bits_nxt;
  logic [7:0]        red_pat_r, red_pat_nxt;
  logic [7:0]        blue_pat_r, blue_pat_nxt;
  logic [DUTY_W-1:0] red_step_r, red_step_nxt;
  logic [DUTY_W-1:0] blue_step_r, blue_step_nxt;
  logic [DUTY_W-1:0] red_duty_r, red_duty_nxt;
  logic [DUTY_W-1:0] blue_duty_r, blue_duty_nxt;
  logic [2:0]        pat_bit_r, pat_bit_nxt;
  logic [TMR_W-1:0]  interval_r, interval_nxt;
  logic [TMR_W-1:0]  time_left_r, time_left_nxt;
  logic              blink_r, blink_nxt;
  logic [DUTY_W-1:0] red_drv_r, red_drv_nxt;
  logic [DUTY_W-1:0] blue_drv_r, blue_drv_nxt;

  logic [7:0]       new_modes;
  logic [TMR_W-1:0] tl_dec;
  logic             expired;
  logic             at_rail;

  function automatic logic [DUTY_W-1:0] ramp(input logic [DUTY_W-1:0] duty,
                                             input logic [DUTY_W-1:0] step,
                                             input logic              up);
    logic [DUTY_W:0] sum;
    sum = {1'b0, duty} + {1'b0, step};
    if (up) begin
      ramp = (sum >= {1'b0, DUTY_MAX}) ? DUTY_MAX : sum[DUTY_W-1:0];
    end else begin
      ramp = (duty >= step) ? duty - step : duty;
    end
  endfunction

  assign tl_dec  = (time_left_r != '0) ? time_left_r - TMR_W'(1) : '0;
  assign expired = (tl_dec == '0);
  assign at_rail = (red_duty_r == '0 || red_duty_r == DUTY_MAX) &&
                   (blue_duty_r == '0 || blue_duty_r == DUTY_MAX);

  always_comb begin
    new_modes = mode_bits_r;
    new_modes[item.mode_index] = item.mode_on;
  end

  always_comb begin
    mode_bits_nxt = mode_bits_r;
    red_pat_nxt   = red_pat_r;
    blue_pat_nxt  = blue_pat_r;
    red_step_nxt  = red_step_r;
    blue_step_nxt = blue_step_r;
    red_duty_nxt  = red_duty_r;
    blue_duty_nxt = blue_duty_r;
    pat_bit_nxt   = pat_bit_r;
    interval_nxt  = interval_r;
    time_left_nxt = time_left_r;
    blink_nxt     = blink_r;
    red_drv_nxt   = red_drv_r;
    blue_drv_nxt  = blue_drv_r;
    if (item.operation == OP_MODE) begin
      // Drop the change when display is off or the bit already matches.
      if (cfg.led_display_enabled && mode_bits_r[item.mode_index] != item.mode_on) begin
        mode_bits_nxt = new_modes;
        if (new_modes[cfg.low_battery_bit]) begin
          red_pat_nxt  = PAT_BLINK;
          red_step_nxt = STEP_RAMP;
          pat_bit_nxt  = '0;
          interval_nxt = RELOAD_MS;
        end else begin
          red_pat_nxt = '0;
        end
        if (new_modes[cfg.wps_bit]) begin
          blue_pat_nxt  = PAT_BLINK;
          blue_step_nxt = STEP_RAMP;
          pat_bit_nxt   = '0;
          interval_nxt  = RELOAD_MS;
        end else if (new_modes[cfg.night_lamp_bit]) begin
          blue_pat_nxt  = PAT_SOLID;
          blue_step_nxt = DUTY_MAX;
          pat_bit_nxt   = '0;
          interval_nxt  = RELOAD_MS;
        end else begin
          blue_pat_nxt = '0;
        end
      end
    end else begin
      time_left_nxt = tl_dec;
      if (!item.module_active || item.sleep_leds_off) begin
        red_drv_nxt  = '0;
        blue_drv_nxt = '0;
      end else if (item.test_blink) begin
        if (expired) begin
          time_left_nxt = BLINK_MS;
          blink_nxt     = !blink_r;
          red_drv_nxt   = !blink_r ? DUTY_W'(100) : '0;
          blue_drv_nxt  = !blink_r ? DUTY_W'(100) : '0;
        end
      end else if (expired) begin
        time_left_nxt = interval_r;
        // Advance the pattern bit when both duties sit at a rail, then ramp toward it.
        pat_bit_nxt   = at_rail ? pat_bit_r + 3'd1 : pat_bit_r;
        red_duty_nxt  = ramp(red_duty_r, red_step_r, red_pat_r[pat_bit_nxt]);
        blue_duty_nxt = ramp(blue_duty_r, blue_step_r, blue_pat_r[pat_bit_nxt]);
        red_drv_nxt   = red_duty_nxt;
        blue_drv_nxt  = blue_duty_nxt;
      end
    end
  end

  assign res.red_drive    = red_drv_nxt;
  assign res.blue_drive   = blue_drv_nxt;
  assign res.active_modes = mode_bits_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_bits_r <= '0;
      red_pat_r   <= '0;
      blue_pat_r  <= '0;
      red_step_r  <= '0;
      blue_step_r <= '0;
      red_duty_r  <= '0;
      blue_duty_r <= '0;
      pat_bit_r   <= '0;
      interval_r  <= '0;
      time_left_r <= '0;
      blink_r     <= 1'b0;
      red_drv_r   <= '0;
      blue_drv_r  <= '0;
    end else if (take) begin
      mode_bits_r <= mode_bits_nxt;
      red_pat_r   <= red_pat_nxt;
      blue_pat_r  <= blue_pat_nxt;
      red_step_r  <= red_step_nxt;
      blue_step_r <= blue_step_nxt;
      red_duty_r  <= red_duty_nxt;
      blue_duty_r <= blue_duty_nxt;
      pat_bit_r   <= pat_bit_nxt;
      interval_r  <= interval_nxt;
      time_left_r <= time_left_nxt;
      blink_r     <= blink_nxt;
      red_drv_r   <= red_drv_nxt;
      blue_drv_r  <= blue_drv_nxt;
    end
  end

  `ASSERT_CLKD(a_mode_keeps_drive, clk, rst_n,
    (take && item.operation == OP_MODE) |=> ($stable(red_drv_r) && $stable(blue_drv_r)))
  `ASSERT_CLKD(a_tick_keeps_modes, clk, rst_n,
    (take && item.operation == OP_TICK) |=> $stable(mode_bits_r))
  `ASSERT_CLKD(a_duty_bounded, clk, rst_n,
    (red_duty_r <= DUTY_MAX) && (blue_duty_r <= DUTY_MAX) && (red_drv_r <= DUTY_MAX))

endmodule

FILE: rtl/core/tlbp_out_stage.sv
// Result register: drives, PWM compare values and mode bits of one beat.
module tlbp_out_stage (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                take,
  input  tlbp_pkg::res_t      res,
  output logic                load_ok,
  output logic                out_valid,
  input  logic                out_ready,
  output tlbp_pkg::out_item_t out_data
);
  import tlbp_pkg::*;

  logic      valid_r, valid_nxt;
  out_item_t data_r, data_nxt;

  assign load_ok   = !valid_r || out_ready;
  assign valid_nxt = take ? 1'b1 : (out_ready ? 1'b0 : valid_r);

  always_comb begin
    data_nxt.red_drive    = res.red_drive;
    data_nxt.blue_drive   = res.blue_drive;
    data_nxt.red_compare  = CMP_LUT[res.red_drive];
    data_nxt.blue_compare = CMP_LUT[res.blue_drive];
    data_nxt.active_modes = res.active_modes;
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      data_r <= data_nxt;
    end
  end

endmodule

FILE: rtl/core/two_led_breathing_pattern.sv
// Top level of the two-LED breathing pattern block.
// Input beats carry either a one-millisecond tick or a mode change; each
// accepted beat yields exactly one result beat with the red and blue duty
// percent, their PWM compare values and the current mode bits.
// Both channels use valid/ready. A beat is registered on acceptance, updated
// through the engine as it moves into the result register, and shown on
// out_valid once the result register has loaded it.
// With out_ready high, throughput is one beat per cycle: the engine state
// updates in the same cycle a beat moves from input to result register.
// When the receiver stalls, the result register holds, the input register
// fills if it is empty, and in_ready then drops until out_ready returns.
// The configuration port (cfg_we, cfg_index, cfg_wdata) writes one register
// per cycle with no wait; write it only while the block is idle.
// Synchronous active-low reset clears the engine state and both registers'
// valid flags, not their data, and loads the register defaults: display
// enabled, low battery on mode bit 0, WPS on bit 1, night lamp on bit 2.
module two_led_breathing_pattern (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  tlbp_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output tlbp_pkg::out_item_t out_data,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [2:0]          cfg_wdata
);
  import tlbp_pkg::*;

  `include "assert_macros.svh"

  cfg_t     cfg_r, cfg_nxt;
  logic     item_valid;
  in_item_t item;
  logic     load_ok;
  logic     take;
  res_t     res;

  assign take = item_valid && load_ok;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_DISPLAY_EN: cfg_nxt.led_display_enabled = cfg_wdata[0];
        CFG_LOW_BAT:    cfg_nxt.low_battery_bit     = cfg_wdata;
        CFG_WPS:        cfg_nxt.wps_bit             = cfg_wdata;
        CFG_NIGHT:      cfg_nxt.night_lamp_bit      = cfg_wdata;
        default:        cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.led_display_enabled <= 1'b1;
      cfg_r.low_battery_bit     <= 3'd0;
      cfg_r.wps_bit             <= 3'd1;
      cfg_r.night_lamp_bit      <= 3'd2;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  tlbp_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .take       (take),
    .item_valid (item_valid),
    .item       (item)
  );

  tlbp_engine u_engine (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg   (cfg_r),
    .take  (take),
    .item  (item),
    .res   (res)
  );

  tlbp_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .take      (take),
    .res       (res),
    .load_ok   (load_ok),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  `ASSERT_CLKD(a_ready_only_on_stall, clk, rst_n,
    !in_ready |-> (out_valid && !out_ready && item_valid))
  `ASSERT_CLKD(a_take_fills_out, clk, rst_n,
    take |=> out_valid)
  `ASSERT_CLKD(a_out_holds, clk, rst_n,
    (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))

endmodule
